// ===== rtl/core/hlfd_pkg.sv =====
// ----------------------------------------------------------------------------
// hlfd_pkg
// Shared types and constants of the header/length frame deframer.
// ----------------------------------------------------------------------------
package hlfd_pkg;

  localparam int FRAME_CAPACITY      = 256;
  localparam int LENGTH_FIELD_OFFSET = 10;
  localparam int QUEUE_DEPTH         = 2;

  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 9;
  localparam int EXP_W   = 10;
  localparam int CNT_W   = 32;
  localparam int CIDX_W  = 3;
  localparam int CDATA_W = 9;
  localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CIDX_W-1:0] {
    REG_HEADER_FIRST     = 3'd0,
    REG_HEADER_SECOND    = 3'd1,
    REG_MIN_FRAME_SIZE   = 3'd2,
    REG_MAX_PAYLOAD_SIZE = 3'd3,
    REG_MAX_FRAME_SIZE   = 3'd4
  } reg_index_t;

  typedef enum logic [3:0] {
    ST_DROPPED    = 4'd0,
    ST_START      = 4'd1,
    ST_RESTART    = 4'd2,
    ST_MISMATCH   = 4'd3,
    ST_STORED     = 4'd4,
    ST_COMPLETE   = 4'd5,
    ST_BADLEN     = 4'd6,
    ST_OVERFLOW   = 4'd7,
    ST_ABORTED    = 4'd8,
    ST_ABORT_IDLE = 4'd9
  } status_t;

  typedef struct packed {
    logic [LEN_W-1:0]  min_frame_size;
    logic [BYTE_W-1:0] max_payload_size;
    logic [LEN_W-1:0]  max_frame_size;
  } cfg_t;

  typedef struct packed {
    logic              func;
    logic [BYTE_W-1:0] rx_byte;
    logic              hit_first;
    logic              hit_second;
  } item_t;

endpackage

// ===== rtl/core/header_length_frame_deframer_top.sv =====
// ----------------------------------------------------------------------------
// header_length_frame_deframer_top
// Byte-stream deframer with a two-byte header and a length field.
// An accepted item enters the queue; the frame engine pops it from the queue
// head and writes its result into the output register. Throughput: one item
// per cycle, set by the frame engine step, unless out_stall holds the result.
// A two-entry queue separates input and engine, and the output register
// holds a result while the next items keep arriving.
// Reset clears the frame state, counters and queue, and loads the register
// defaults.
// ----------------------------------------------------------------------------
module header_length_frame_deframer_top
  import hlfd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CIDX_W-1:0]  cfg_index,
  input  logic [CDATA_W-1:0] cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               func,
  input  logic [BYTE_W-1:0]  rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         status,
  output logic [BYTE_W-1:0]  frame_byte,
  output logic [BYTE_W-1:0]  byte_offset,
  output logic [LEN_W-1:0]   frame_length,
  output logic [CNT_W-1:0]   dropped_byte_total,
  output logic [CNT_W-1:0]   rejected_frame_total,
  output logic [CNT_W-1:0]   completed_frame_total,
  output logic [CNT_W-1:0]   aborted_frame_total
);

  item_t front_item;
  item_t q_head;
  cfg_t  cfg;
  logic  q_full;
  logic  q_not_empty;
  logic  q_pop;

  assign in_stall = q_full;

  hlfd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .func      (func),
    .rx_byte   (rx_byte),
    .item      (front_item),
    .cfg       (cfg)
  );

  hlfd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid && !in_stall),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  hlfd_back u_back (
    .clk                   (clk),
    .rst                   (rst),
    .cfg                   (cfg),
    .q_not_empty           (q_not_empty),
    .q_head                (q_head),
    .q_pop                 (q_pop),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .status                (status),
    .frame_byte            (frame_byte),
    .byte_offset           (byte_offset),
    .frame_length          (frame_length),
    .dropped_byte_total    (dropped_byte_total),
    .rejected_frame_total  (rejected_frame_total),
    .completed_frame_total (completed_frame_total),
    .aborted_frame_total   (aborted_frame_total)
  );

endmodule

// ===== rtl/core/hlfd_front.sv =====
// ----------------------------------------------------------------------------
// hlfd_front
// Holds the configuration registers and classifies each incoming byte
// against the two header values before it enters the queue.
// ----------------------------------------------------------------------------
module hlfd_front
  import hlfd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CIDX_W-1:0]  cfg_index,
  input  logic [CDATA_W-1:0] cfg_data,
  input  logic               func,
  input  logic [BYTE_W-1:0]  rx_byte,
  output item_t              item,
  output cfg_t               cfg
);

  logic [BYTE_W-1:0] header_first;
  logic [BYTE_W-1:0] header_second;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_first         <= BYTE_W'(170);
      header_second        <= BYTE_W'(85);
      cfg.min_frame_size   <= LEN_W'(13);
      cfg.max_payload_size <= BYTE_W'(200);
      cfg.max_frame_size   <= LEN_W'(256);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HEADER_FIRST:     header_first         <= cfg_data[BYTE_W-1:0];
        REG_HEADER_SECOND:    header_second        <= cfg_data[BYTE_W-1:0];
        REG_MIN_FRAME_SIZE:   cfg.min_frame_size   <= cfg_data[LEN_W-1:0];
        REG_MAX_PAYLOAD_SIZE: cfg.max_payload_size <= cfg_data[BYTE_W-1:0];
        REG_MAX_FRAME_SIZE:   cfg.max_frame_size   <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    item.func       = func;
    item.rx_byte    = rx_byte;
    item.hit_first  = (rx_byte == header_first);
    item.hit_second = (rx_byte == header_second);
  end

endmodule

// ===== rtl/core/hlfd_queue.sv =====
// ----------------------------------------------------------------------------
// hlfd_queue
// Small register queue between the classifying front and the frame engine.
// ----------------------------------------------------------------------------
module hlfd_queue
  import hlfd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  not_empty,
  output item_t head
);

  item_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/core/hlfd_back.sv =====
// ----------------------------------------------------------------------------
// hlfd_back
// Frame engine: tracks header hunt, frame length and outcome counters, and
// holds one finished result in an output register.
// ----------------------------------------------------------------------------
module hlfd_back
  import hlfd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              q_not_empty,
  input  item_t             q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [3:0]        status,
  output logic [BYTE_W-1:0] frame_byte,
  output logic [BYTE_W-1:0] byte_offset,
  output logic [LEN_W-1:0]  frame_length,
  output logic [CNT_W-1:0]  dropped_byte_total,
  output logic [CNT_W-1:0]  rejected_frame_total,
  output logic [CNT_W-1:0]  completed_frame_total,
  output logic [CNT_W-1:0]  aborted_frame_total
);

  logic [LEN_W-1:0]  current_length;
  logic [LEN_W-1:0]  current_length_next;
  logic [EXP_W-1:0]  target_length;
  logic [EXP_W-1:0]  target_length_next;
  logic [CNT_W-1:0]  dropped_count;
  logic [CNT_W-1:0]  dropped_count_next;
  logic [CNT_W-1:0]  rejected_count;
  logic [CNT_W-1:0]  rejected_count_next;
  logic [CNT_W-1:0]  completed_count;
  logic [CNT_W-1:0]  completed_count_next;
  logic [CNT_W-1:0]  aborted_count;
  logic [CNT_W-1:0]  aborted_count_next;
  status_t           res_status;
  logic [BYTE_W-1:0] res_byte;
  logic [BYTE_W-1:0] res_offset;
  logic [LEN_W-1:0]  res_length;
  logic [LEN_W-1:0]  limit;
  logic [LEN_W-1:0]  length_inc;
  logic              out_valid_next;

  assign q_pop = q_not_empty && (!out_valid || !out_stall);

  always_comb begin
    limit = (cfg.max_frame_size > LEN_W'(FRAME_CAPACITY)) ?
            LEN_W'(FRAME_CAPACITY) : cfg.max_frame_size;
    length_inc           = current_length + 1'b1;
    current_length_next  = current_length;
    target_length_next   = target_length;
    dropped_count_next   = dropped_count;
    rejected_count_next  = rejected_count;
    completed_count_next = completed_count;
    aborted_count_next   = aborted_count;
    res_status           = ST_DROPPED;
    res_byte             = '0;
    res_offset           = '0;
    res_length           = '0;

    if (q_head.func) begin
      if (current_length != '0) begin
        aborted_count_next  = aborted_count + 1'b1;
        current_length_next = '0;
        target_length_next  = '0;
        res_status          = ST_ABORTED;
      end else begin
        res_status = ST_ABORT_IDLE;
      end
      res_length = '0;
    end else if (current_length == '0) begin
      if (q_head.hit_first) begin
        current_length_next = LEN_W'(1);
        res_byte            = q_head.rx_byte;
        res_status          = ST_START;
      end else begin
        dropped_count_next = dropped_count + 1'b1;
        res_status         = ST_DROPPED;
      end
      res_length = current_length_next;
    end else if (current_length == LEN_W'(1)) begin
      if (q_head.hit_second) begin
        current_length_next = LEN_W'(2);
        res_byte            = q_head.rx_byte;
        res_offset          = BYTE_W'(1);
        res_status          = ST_STORED;
      end else if (q_head.hit_first) begin
        dropped_count_next = dropped_count + 1'b1;
        res_byte           = q_head.rx_byte;
        res_status         = ST_RESTART;
      end else begin
        dropped_count_next  = dropped_count + CNT_W'(2);
        current_length_next = '0;
        target_length_next  = '0;
        res_status          = ST_MISMATCH;
      end
      res_length = current_length_next;
    end else if (current_length >= limit) begin
      rejected_count_next = rejected_count + 1'b1;
      current_length_next = '0;
      target_length_next  = '0;
      res_status          = ST_OVERFLOW;
      res_length          = '0;
    end else begin
      res_byte            = q_head.rx_byte;
      res_offset          = current_length[BYTE_W-1:0];
      current_length_next = length_inc;
      res_status          = ST_STORED;
      res_length          = length_inc;
      if (current_length == LEN_W'(LENGTH_FIELD_OFFSET)) begin
        if (q_head.rx_byte > cfg.max_payload_size) begin
          rejected_count_next = rejected_count + 1'b1;
          current_length_next = '0;
          target_length_next  = '0;
          res_status          = ST_BADLEN;
          res_length          = '0;
        end else begin
          target_length_next = EXP_W'(cfg.min_frame_size) + EXP_W'(q_head.rx_byte);
        end
      end
      if (res_status == ST_STORED && target_length_next != '0 &&
          EXP_W'(length_inc) == target_length_next) begin
        completed_count_next = completed_count + 1'b1;
        current_length_next  = '0;
        target_length_next   = '0;
        res_status           = ST_COMPLETE;
      end
    end
  end

  always_comb begin
    if (q_pop) begin
      out_valid_next = 1'b1;
    end else if (out_stall) begin
      out_valid_next = out_valid;
    end else begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_length  <= '0;
      target_length   <= '0;
      dropped_count   <= '0;
      rejected_count  <= '0;
      completed_count <= '0;
      aborted_count   <= '0;
      out_valid       <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      if (q_pop) begin
        current_length  <= current_length_next;
        target_length   <= target_length_next;
        dropped_count   <= dropped_count_next;
        rejected_count  <= rejected_count_next;
        completed_count <= completed_count_next;
        aborted_count   <= aborted_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      status                <= res_status;
      frame_byte            <= res_byte;
      byte_offset           <= res_offset;
      frame_length          <= res_length;
      dropped_byte_total    <= dropped_count_next;
      rejected_frame_total  <= rejected_count_next;
      completed_frame_total <= completed_count_next;
      aborted_frame_total   <= aborted_count_next;
    end
  end

endmodule

// ===== rtl/core/hlfd_checker.sv =====
// ----------------------------------------------------------------------------
// hlfd_checker
// Port-level assertions for the deframer, bound to the top level.
// ----------------------------------------------------------------------------
module hlfd_checker
  import hlfd_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input logic [3:0]         status,
  input logic [BYTE_W-1:0]  frame_byte,
  input logic [BYTE_W-1:0]  byte_offset,
  input logic [LEN_W-1:0]   frame_length,
  input logic [CNT_W-1:0]   completed_frame_total
);

  // A stalled result holds until it is transferred.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) &&
      $stable(frame_byte) && $stable(completed_frame_total))
    else $error("stalled result changed");

  // Dropped, mismatch, overflow and abort outcomes show a zero byte and offset.
  a_no_store: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_DROPPED || status == ST_MISMATCH ||
      status == ST_OVERFLOW || status == ST_ABORTED || status == ST_ABORT_IDLE)
    |-> frame_byte == '0 && byte_offset == '0)
    else $error("byte or offset reported for an outcome that stores nothing");

  // A frame start is the first byte of a frame.
  a_start: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_START |-> byte_offset == '0 &&
      frame_length == LEN_W'(1))
    else $error("frame start with wrong offset or length");

  // Rejected or aborted frames report a zero length.
  a_reject_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_BADLEN || status == ST_OVERFLOW ||
      status == ST_ABORTED || status == ST_ABORT_IDLE) |-> frame_length == '0)
    else $error("nonzero length on a dropped frame");

endmodule

bind header_length_frame_deframer_top hlfd_checker u_hlfd_checker (
  .clk                   (clk),
  .rst                   (rst),
  .out_valid             (out_valid),
  .out_stall             (out_stall),
  .status                (status),
  .frame_byte            (frame_byte),
  .byte_offset           (byte_offset),
  .frame_length          (frame_length),
  .completed_frame_total (completed_frame_total)
);
